### rtl/cbpe_pkg.sv
// cbpe_pkg: shared constants for the cubic bezier point evaluator
// register indexes of the control point registers and pipeline sizing
// no dependencies
`default_nettype none

package cbpe_pkg;

   localparam int CSR_INDEX_BITS = 4;
   localparam int NUM_AXES       = 2;
   localparam int NUM_POINTS     = 4;
   localparam int NUM_STAGES     = 8;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_X0 = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_X1 = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_X2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_X3 = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_Y0 = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_Y1 = CSR_INDEX_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_Y2 = CSR_INDEX_BITS'(6);
   localparam logic [CSR_INDEX_BITS-1:0] REG_CTRL_Y3 = CSR_INDEX_BITS'(7);

endpackage

`default_nettype wire

### rtl/cubic_bezier_point_evaluator.sv
// cubic_bezier_point_evaluator: pipelined power-basis evaluation of a cubic bezier curve
// depends on cbpe_pkg for register indexes and stage count
//
//   channel | ports                                  | direction | moves
//   --------+----------------------------------------+-----------+--------------------------
//   req     | req_valid req_ready req_t_fraction     | in        | one t per request
//   rsp     | rsp_valid rsp_ready rsp_pixel_x/_y     | out       | one point per request
//   csr     | csr_valid csr_ready csr_index csr_wdata| in        | control point write
//
// eight register stages; one request per cycle is sustained while rsp_ready stays high. the depth
// comes from the horner chain: a*t, then two products of the partial sum with t, each split
// into a high and a low product.
// reset clears the control points, the derived coefficients and all stage valid bits.
// each stage holds only while it is full and the one after it is stalled, so an empty stage always
// fills: requests keep entering while a finished point waits on rsp_ready, until every stage is full.
`default_nettype none

module cubic_bezier_point_evaluator #(
   parameter int T_FRACTION_BITS = 16,
   parameter int COORD_BITS      = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [T_FRACTION_BITS-1:0]           req_t_fraction,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [COORD_BITS-1:0]              rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]              rsp_pixel_y,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cbpe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]                csr_wdata
);
   import cbpe_pkg::*;

   localparam int F   = T_FRACTION_BITS;
   localparam int C   = COORD_BITS;
   localparam int AW  = C + 3;          // a and c
   localparam int BW  = C + 4;          // b
   localparam int MW1 = AW + F;         // a*t
   localparam int W1  = C + F + 5;      // a*t + b*s
   localparam int PHW = (W1 - F) + F;   // high part of acc1 times t
   localparam int PLW = 2 * F;          // low part of acc1 times t
   localparam int W2  = C + 2 * F + 5;  // acc1*t + c*s^2
   localparam int QHW = (W2 - 2 * F) + F;
   localparam int QLW = 3 * F;
   localparam int SW  = QHW + 1;
   localparam int VW  = SW - F + 1;
   localparam logic signed [VW-1:0] PIX_MAX = VW'((2 ** (C - 1)) - 1);
   localparam logic signed [VW-1:0] PIX_MIN = VW'(-(2 ** (C - 1)));
   localparam logic [QLW:0] ROUND_HALF = (QLW + 1)'(1) << (QLW - 1);

   // control points and derived power-basis coefficients
   logic signed [C-1:0]  ctrl_ff   [NUM_AXES][NUM_POINTS];
   logic signed [AW-1:0] coef_a_ff [NUM_AXES];
   logic signed [BW-1:0] coef_b_ff [NUM_AXES];
   logic signed [AW-1:0] coef_c_ff [NUM_AXES];
   logic signed [C-1:0]  coef_d_ff [NUM_AXES];
   logic signed [AW-1:0] coef_a_in [NUM_AXES];
   logic signed [BW-1:0] coef_b_in [NUM_AXES];
   logic signed [AW-1:0] coef_c_in [NUM_AXES];

   // stage control
   logic                 vld_ff [1:NUM_STAGES];
   logic                 vld_in [1:NUM_STAGES];
   logic                 en     [1:NUM_STAGES];
   logic [F-1:0]         t_ff   [1:5];

   // per-axis datapath
   logic signed [MW1-1:0] m1_ff   [NUM_AXES];
   logic signed [MW1-1:0] m1_in   [NUM_AXES];
   logic signed [W1-1:0]  acc1_ff [NUM_AXES];
   logic signed [W1-1:0]  acc1_in [NUM_AXES];
   logic signed [PHW-1:0] ph_ff   [NUM_AXES];
   logic signed [PHW-1:0] ph_in   [NUM_AXES];
   logic [PLW-1:0]        pl_ff   [NUM_AXES];
   logic [PLW-1:0]        pl_in   [NUM_AXES];
   logic signed [W2-1:0]  acc2_ff [NUM_AXES];
   logic signed [W2-1:0]  acc2_in [NUM_AXES];
   logic signed [QHW-1:0] qh_ff   [NUM_AXES];
   logic signed [QHW-1:0] qh_in   [NUM_AXES];
   logic [QLW-1:0]        ql_ff   [NUM_AXES];
   logic [QLW-1:0]        ql_in   [NUM_AXES];
   logic [QLW:0]          rnd     [NUM_AXES];
   logic signed [SW-1:0]  s_ff    [NUM_AXES];
   logic signed [SW-1:0]  s_in    [NUM_AXES];
   logic signed [VW-1:0]  v_sum   [NUM_AXES];
   logic signed [C-1:0]   pix_ff  [NUM_AXES];
   logic signed [C-1:0]   pix_in  [NUM_AXES];

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            for (int j = 0; j < NUM_POINTS; j++) begin
               ctrl_ff[i][j] <= '0;
            end
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_CTRL_X0: ctrl_ff[AXIS_X][0] <= csr_wdata;
            REG_CTRL_X1: ctrl_ff[AXIS_X][1] <= csr_wdata;
            REG_CTRL_X2: ctrl_ff[AXIS_X][2] <= csr_wdata;
            REG_CTRL_X3: ctrl_ff[AXIS_X][3] <= csr_wdata;
            REG_CTRL_Y0: ctrl_ff[AXIS_Y][0] <= csr_wdata;
            REG_CTRL_Y1: ctrl_ff[AXIS_Y][1] <= csr_wdata;
            REG_CTRL_Y2: ctrl_ff[AXIS_Y][2] <= csr_wdata;
            REG_CTRL_Y3: ctrl_ff[AXIS_Y][3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   always_comb begin
      en[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k + 1];
      end
      vld_in[1] = en[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= NUM_STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k - 1] : vld_ff[k];
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = vld_ff[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   // t travels with the request up to the last multiply stage
   always_ff @(posedge clock) begin
      if (en[1]) begin
         t_ff[1] <= req_t_fraction;
      end
      for (int k = 2; k <= 5; k++) begin
         if (en[k]) begin
            t_ff[k] <= t_ff[k - 1];
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      logic signed [BW-1:0] e0, e1, e2, e3;

      assign e0 = BW'(ctrl_ff[g][0]);
      assign e1 = BW'(ctrl_ff[g][1]);
      assign e2 = BW'(ctrl_ff[g][2]);
      assign e3 = BW'(ctrl_ff[g][3]);

      // rows of the bezier basis matrix: -1 3 -3 1 / 3 -6 3 0 / -3 3 0 0 / 1 0 0 0
      always_comb begin
         coef_a_in[g] = AW'((e3 - e0) + ((e1 - e2) <<< 1) + (e1 - e2));
         coef_b_in[g] = ((e0 + e2) <<< 1) + (e0 + e2) - (e1 <<< 2) - (e1 <<< 1);
         coef_c_in[g] = AW'(((e1 - e0) <<< 1) + (e1 - e0));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            coef_a_ff[g] <= '0;
            coef_b_ff[g] <= '0;
            coef_c_ff[g] <= '0;
            coef_d_ff[g] <= '0;
         end else begin
            coef_a_ff[g] <= coef_a_in[g];
            coef_b_ff[g] <= coef_b_in[g];
            coef_c_ff[g] <= coef_c_in[g];
            coef_d_ff[g] <= ctrl_ff[g][0];
         end
      end

      // horner: ((a*t + b*s)*t + c*s^2)*t + d*s^3, wide operands split at multiples of s
      always_comb begin
         m1_in[g]   = MW1'(coef_a_ff[g]) * MW1'($signed({1'b0, t_ff[1]}));
         acc1_in[g] = W1'(m1_ff[g]) + (W1'(coef_b_ff[g]) <<< F);
         ph_in[g]   = PHW'($signed(acc1_ff[g][W1-1:F])) * PHW'($signed({1'b0, t_ff[3]}));
         pl_in[g]   = PLW'(acc1_ff[g][F-1:0]) * PLW'(t_ff[3]);
         acc2_in[g] = (W2'(ph_ff[g]) <<< F) + W2'($signed({1'b0, pl_ff[g]}))
                    + (W2'(coef_c_ff[g]) <<< (2 * F));
         qh_in[g]   = QHW'($signed(acc2_ff[g][W2-1:2*F]))
                    * QHW'($signed({1'b0, t_ff[5]}));
         ql_in[g]   = QLW'(acc2_ff[g][2*F-1:0]) * QLW'(t_ff[5]);
         // low product plus half; its bits from 2*F up, carry included, are added to the high part
         rnd[g]     = (QLW + 1)'(ql_ff[g]) + ROUND_HALF;
         s_in[g]    = SW'(qh_ff[g]) + SW'($signed({1'b0, rnd[g][QLW:2*F]}));
         v_sum[g]   = VW'($signed(s_ff[g][SW-1:F])) + VW'(coef_d_ff[g]);
         if (v_sum[g] > PIX_MAX) begin
            pix_in[g] = C'(PIX_MAX);
         end else if (v_sum[g] < PIX_MIN) begin
            pix_in[g] = C'(PIX_MIN);
         end else begin
            pix_in[g] = C'(v_sum[g]);
         end
      end

      always_ff @(posedge clock) begin
         if (en[2]) begin
            m1_ff[g] <= m1_in[g];
         end
         if (en[3]) begin
            acc1_ff[g] <= acc1_in[g];
         end
         if (en[4]) begin
            ph_ff[g] <= ph_in[g];
            pl_ff[g] <= pl_in[g];
         end
         if (en[5]) begin
            acc2_ff[g] <= acc2_in[g];
         end
         if (en[6]) begin
            qh_ff[g] <= qh_in[g];
            ql_ff[g] <= ql_in[g];
         end
         if (en[7]) begin
            s_ff[g] <= s_in[g];
         end
         if (en[8]) begin
            pix_ff[g] <= pix_in[g];
         end
      end
   end

   assign rsp_pixel_x = pix_ff[AXIS_X];
   assign rsp_pixel_y = pix_ff[AXIS_Y];

endmodule

`default_nettype wire
